// File: hw/rtl/ptc_pkg.sv
// Shared types, constants and arithmetic helpers for the barometer compensation block
`timescale 1ns / 1ps
package ptc_pkg;

  // Register indexes on the configuration port
  localparam logic [1:0] REG_TEMP_CALIB = 2'd0;
  localparam logic [1:0] REG_PRESS_A    = 2'd1;
  localparam logic [1:0] REG_PRESS_B    = 2'd2;
  localparam logic [1:0] REG_PRESS_C    = 2'd3;

  localparam logic [31:0] PRESS_OFFSET = 32'd64000;
  localparam logic [31:0] ADC_SPAN     = 32'd1048576;
  localparam logic [31:0] PA_SCALE     = 32'd3125;
  localparam logic [31:0] ROUND_HALF   = 32'd128;
  localparam logic [31:0] P1_BIAS      = 32'd32768;
  localparam logic [31:0] SIGN_BIT     = 32'h8000_0000;

  // Divider width: 32-bit dividend, one quotient bit per stage
  localparam int DIV_BITS = 32;

  // Calibration words after sign or zero extension to 32 bits
  typedef struct packed {
    logic [31:0] t1, t2, t3;
    logic [31:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
  } calib_t;

  // Partial divide state carried from one divider stage to the next
  typedef struct packed {
    logic [31:0] rem;
    logic [31:0] quo;
    logic [31:0] num;
    logic [31:0] den;
    logic        post_shift;
  } div_t;

  // Low 32 bits of a 32x32 product
  function automatic logic [31:0] mul32(input logic [31:0] a, input logic [31:0] b);
    logic [63:0] p;
    p = a * b;
    return p[31:0];
  endfunction

  function automatic logic [31:0] sx16(input logic [15:0] w);
    return {{16{w[15]}}, w};
  endfunction

endpackage

// File: hw/rtl/ptc_div_stage.sv
// One restoring-divide step: produces one quotient bit per stage
`timescale 1ns / 1ps
module ptc_div_stage
  import ptc_pkg::*;
#(
  parameter int BIT = 31
) (
  input  div_t din,
  output div_t dout
);

  logic [32:0] trial;
  logic [31:0] rem_sh;

  // Shift in the next numerator bit and try a subtract
  always_comb begin
    rem_sh = {din.rem[30:0], din.num[BIT]};
    trial  = {1'b0, rem_sh} - {1'b0, din.den};
    dout   = din;
    if (din.rem[31] || !trial[32]) begin
      dout.rem      = trial[31:0];
      dout.quo[BIT] = 1'b1;
    end else begin
      dout.rem = rem_sh;
    end
  end

endmodule

// File: hw/rtl/pressure_temp_compensation.sv
// Top level: pipelined 32-bit integer barometer compensation with APB calibration registers
//
//  channel   | direction | handshake         | payload
//  s_axis    | in        | tvalid/tready     | tdata[19:0] raw_temperature, [39:20] raw_pressure
//  m_axis    | out       | tvalid/tready     | tdata[31:0] temperature_centi, [63:32] pressure_pa;
//            |           |                   | tuser divisor_zero
//  apb       | in        | psel/penable      | 64-bit registers at 8*i
//
// One sample pair enters per cycle while m_axis is not stalled. Stages: 11 arithmetic stages,
// 32 divider stages (one quotient bit each) and 6 stages of final correction.
// Reset clears valid bits and calibration registers. A stall on m_axis freezes
// the whole pipeline in place; s_axis tready follows m_axis readiness of the last stage.
`timescale 1ns / 1ps
module pressure_temp_compensation
  import ptc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // [19:0] raw_temperature, [39:20] raw_pressure
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // [31:0] temperature_centi, [63:32] pressure_pa
  output logic        m_axis_tuser,   // [0] divisor_zero
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  localparam int NPRE = 10;
  localparam int NPOST = 7;
  localparam int NSTG = NPRE + DIV_BITS + NPOST;

  logic [47:0] temp_calib;
  logic [63:0] press_calib_a, press_calib_b;
  logic [15:0] press_calib_c;
  logic [1:0]  reg_idx;
  logic        wr_en;
  calib_t      cal;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:3];
  assign wr_en   = psel && penable && pwrite && (paddr[2:0] == 3'd0);

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      temp_calib    <= '0;
      press_calib_a <= '0;
      press_calib_b <= '0;
      press_calib_c <= '0;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_TEMP_CALIB: temp_calib    <= pwdata[47:0];
        REG_PRESS_A:    press_calib_a <= pwdata;
        REG_PRESS_B:    press_calib_b <= pwdata;
        REG_PRESS_C:    press_calib_c <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Register reads
  always_comb begin
    prdata = '0;
    if (paddr[2:0] == 3'd0) begin
      unique case (reg_idx)
        REG_TEMP_CALIB: prdata = {16'd0, temp_calib};
        REG_PRESS_A:    prdata = press_calib_a;
        REG_PRESS_B:    prdata = press_calib_b;
        REG_PRESS_C:    prdata = {48'd0, press_calib_c};
        default:        prdata = '0;
      endcase
    end
  end

  // Unpack calibration words
  always_comb begin
    cal.t1 = {16'd0, temp_calib[15:0]};
    cal.t2 = sx16(temp_calib[31:16]);
    cal.t3 = sx16(temp_calib[47:32]);
    cal.p1 = {16'd0, press_calib_a[15:0]};
    cal.p2 = sx16(press_calib_a[31:16]);
    cal.p3 = sx16(press_calib_a[47:32]);
    cal.p4 = sx16(press_calib_a[63:48]);
    cal.p5 = sx16(press_calib_b[15:0]);
    cal.p6 = sx16(press_calib_b[31:16]);
    cal.p7 = sx16(press_calib_b[47:32]);
    cal.p8 = sx16(press_calib_b[63:48]);
    cal.p9 = sx16(press_calib_c);
  end

  logic adv;
  logic [NSTG-1:0] vld;
  assign adv = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = adv;
  assign m_axis_tvalid = vld[NSTG-1];

  // Valid bits travel with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[NSTG-2:0], s_axis_tvalid};
    end
  end

  // Pre-divide datapath registers
  logic [31:0] adc_t0, adc_p [0:NPRE-1], temp_r [6:NPRE-1];
  logic [31:0] ta1, td1, dd2, ta2, tb3, fine4, tmul5;
  logic [31:0] pa5, sq6, pa6, b7, c7, e7, f7, b8, e8, b9, a9, den10, num10;
  logic [31:0] fine3;

  always_ff @(posedge clk) begin
    if (adv) begin
      // stage 0: capture
      adc_t0   <= {12'd0, s_axis_tdata[19:0]};
      adc_p[0] <= {12'd0, s_axis_tdata[39:20]};
      for (int i = 1; i < NPRE; i++) adc_p[i] <= adc_p[i-1];
      // stage 1: temperature differences
      ta1 <= (adc_t0 >> 3) - (cal.t1 << 1);
      td1 <= (adc_t0 >> 4) - cal.t1;
      // stage 2: products
      ta2 <= $signed(mul32(ta1, cal.t2)) >>> 11;
      dd2 <= $signed(mul32(td1, td1)) >>> 12;
      // stage 3
      tb3   <= $signed(mul32(dd2, cal.t3)) >>> 14;
      fine3 <= ta2;
      // stage 4: fine temperature
      fine4 <= fine3 + tb3;
      // stage 5
      tmul5 <= mul32(fine4, 32'd5) + ROUND_HALF;
      pa5   <= $unsigned($signed(fine4) >>> 1) - PRESS_OFFSET;
      // stage 6
      temp_r[6] <= $signed(tmul5) >>> 8;
      sq6 <= mul32($signed(pa5) >>> 2, $signed(pa5) >>> 2);
      pa6 <= pa5;
      // stage 7: independent products
      temp_r[7] <= temp_r[6];
      b7 <= mul32($signed(sq6) >>> 11, cal.p6);
      c7 <= mul32(pa6, cal.p5) << 1;
      e7 <= $signed(mul32(cal.p3, $signed(sq6) >>> 13)) >>> 3;
      f7 <= $signed(mul32(cal.p2, pa6)) >>> 1;
      // stage 8
      temp_r[8] <= temp_r[7];
      b8 <= $unsigned($signed(b7 + c7) >>> 2) + (cal.p4 << 16);
      e8 <= $signed(e7 + f7) >>> 18;
      // stage 9
      temp_r[9] <= temp_r[8];
      b9 <= b8;
      a9 <= $signed(mul32(P1_BIAS + e8, cal.p1)) >>> 15;
      // stage 10 (feeds divider): dividend and divisor
      num10 <= mul32((ADC_SPAN - adc_p[NPRE-1]) - $unsigned($signed(b9) >>> 12), PA_SCALE);
      den10 <= a9;
    end
  end

  // Temperature rides alongside the divider and the correction stages
  localparam int NSIDE = DIV_BITS + NPOST - 2;
  logic [31:0] tside [0:NSIDE];
  div_t dv_in;
  div_t dv [1:DIV_BITS];
  div_t dv_next [0:DIV_BITS-1];

  // Divider setup: large dividends divide first and shift afterwards
  always_comb begin
    dv_in.den        = den10;
    dv_in.post_shift = num10[31];
    dv_in.num        = num10[31] ? num10 : (num10 << 1);
    dv_in.rem        = '0;
    dv_in.quo        = '0;
  end

  for (genvar g = 0; g < DIV_BITS; g++) begin : g_div
    if (g == 0) begin : g_first
      ptc_div_stage #(.BIT(DIV_BITS-1)) u_stage (.din(dv_in), .dout(dv_next[g]));
    end else begin : g_rest
      ptc_div_stage #(.BIT(DIV_BITS-1-g)) u_stage (.din(dv[g]), .dout(dv_next[g]));
    end
  end

  // Advance divider stages and the side temperature delay
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < DIV_BITS; i++) dv[i+1] <= dv_next[i];
      tside[0] <= temp_r[9];
      for (int i = 1; i <= NSIDE; i++) tside[i] <= tside[i-1];
    end
  end

  // Post-divide correction
  logic [31:0] q0, pr1, pr2, x2, y2, pr3, x3, y3, pr4, s4;
  logic [NPOST-3:0] zf;
  logic zdiv;
  assign zdiv = (dv[DIV_BITS].den == '0);

  always_ff @(posedge clk) begin
    if (adv) begin
      // restoring divide compare uses 33-bit trial, so rem never overflows
      q0  <= dv[DIV_BITS].post_shift ? (dv[DIV_BITS].quo << 1) : dv[DIV_BITS].quo;
      zf[0] <= zdiv;
      for (int i = 1; i < NPOST - 2; i++) zf[i] <= zf[i-1];
      pr1 <= q0;
      pr2 <= pr1;
      x2  <= mul32(pr1 >> 3, pr1 >> 3) >> 13;
      y2  <= mul32(pr1 >> 2, cal.p8);
      pr3 <= pr2;
      x3  <= $signed(mul32(cal.p9, x2)) >>> 12;
      y3  <= $signed(y2) >>> 13;
      pr4 <= pr3;
      s4  <= x3 + y3 + cal.p7;
      m_axis_tdata[31:0]  <= tside[NSIDE];
      m_axis_tdata[63:32] <= zf[NPOST-3] ? 32'd0 : pr4 + $unsigned($signed(s4) >>> 4);
      m_axis_tuser        <= zf[NPOST-3];
    end
  end

  // Assertions
  a_zero_pa: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[63:32] == 32'd0)
    else $error("pressure not zero on divisor error");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output changed under stall");
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output");

endmodule
